// File: rtl/chs_pkg.sv
// Package for the chained hash set: item types, operation and status codes, FSM states.
// No dependencies.
package chs_pkg;
    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF = 256;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_MISSING  = 3'd2,
        ST_DELETED  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] bucket;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_NODE_WAIT,
        S_FREE_WAIT,
        S_DEL_FIX,
        S_DONE
    } t_state;
endpackage

// File: rtl/chs_hash.sv
// Bucket hash unit: non-negative remainder of a signed key by the bucket count,
// one quotient bit per cycle (restoring division).
module chs_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_key,
    input  logic [6:0]  i_div,
    output logic        o_done,
    output logic [6:0]  o_rem
);
    logic [31:0] r_mag;
    logic [6:0]  r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;
    logic [7:0]  w_trial;
    logic [6:0]  w_fix;

    assign w_trial = {r_rem, r_mag[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= 7'd0;
                r_neg  <= i_key[31];
                r_mag  <= i_key[31] ? (~i_key + 32'd1) : i_key;
            end else if (r_busy) begin
                r_mag <= {r_mag[30:0], 1'b0};
                if (w_trial >= {1'b0, i_div}) begin
                    r_rem <= 7'(w_trial - {1'b0, i_div});
                end else begin
                    r_rem <= w_trial[6:0];
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_fix = (r_neg && r_rem != 7'd0) ? 7'(i_div - r_rem) : r_rem;
    assign o_rem = w_fix;
    assign o_done = r_done;
endmodule

// File: rtl/chained_hash_set_core.sv
// Top level of the chained hash set: control FSM with bucket head and node memories.
// Uses chs_pkg and chs_hash.
//
//  Channel | Direction | Signals
//  in      | input     | i_in_valid, o_in_stall, i_in_item
//  out     | output    | o_out_valid, i_out_stall, o_out_item
//  cfg     | input     | i_cfg_we, i_cfg_data
//
// An item is accepted only in idle and then runs the hash, head read, head wait and done states.
// The serial hash works one quotient bit per cycle; each chain node visited adds a node wait.
// A delete that unlinks a node and an insert that reuses a freed node each add a further state.
// Reset empties every chain at once through per-bucket valid bits; node memory is not cleared.
// A finished result waits in the output register while the next item is accepted and worked;
// the input stalls when that next result is ready before the first one has left.
module chained_hash_set_core #(
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
    parameter int NODES   = chs_pkg::NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chs_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chs_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);
    localparam int LW = NW + 1;
    localparam logic [LW-1:0] NIL = LW'(NODES);

    chs_pkg::t_state r_state, n_state;

    logic [6:0]    r_cfg;
    logic [6:0]    w_div;
    logic [31:0]   r_key;
    logic [1:0]    r_kind;
    logic [BW-1:0] r_bkt;
    logic [5:0]    r_bkt_out;
    logic [LW-1:0] r_free, r_fresh, r_cur, r_prev, r_nxt_cur;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [2:0]    r_out_status_q;
    logic [5:0]    r_out_bucket;
    logic          w_hash_done;
    logic [6:0]    w_rem;
    logic          w_start;
    logic          w_accept;
    logic [LW:0]   r_steps;

    logic [LW-1:0] r_heads [BUCKETS];
    logic [BUCKETS-1:0] r_hvalid;
    logic [LW-1:0] r_head_q;
    logic          r_head_qv;

    logic [31:0]   r_nkey [NODES];
    logic [LW-1:0] r_nlink [NODES];
    logic [31:0]   r_nkey_q;
    logic [LW-1:0] r_nlink_q;

    logic          w_hd_we;
    logic [LW-1:0] w_hd_wd;
    logic          w_nd_re;
    logic [NW-1:0] w_nd_ra;
    logic          w_nk_we, w_nl_we;
    logic [NW-1:0] w_nk_wa, w_nl_wa;
    logic [LW-1:0] w_nl_wd;
    logic [LW-1:0] w_head;

    assign w_div = (r_cfg == 7'd0) ? 7'd1 :
                   ({25'd0, r_cfg} > 32'(BUCKETS)) ? 7'(BUCKETS) : r_cfg;

    assign o_in_stall = (r_state != chs_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = w_accept;
    assign w_head     = r_head_qv ? r_head_q : NIL;

    chs_hash u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_key  (i_in_item.key),
        .i_div  (w_div),
        .o_done (w_hash_done),
        .o_rem  (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chs_pkg::S_IDLE: begin
                if (w_accept) n_state = chs_pkg::S_HASH;
            end
            chs_pkg::S_HASH: begin
                if (w_hash_done) n_state = chs_pkg::S_HEAD_RD;
            end
            chs_pkg::S_HEAD_RD: n_state = chs_pkg::S_HEAD_WAIT;
            chs_pkg::S_HEAD_WAIT: begin
                if (r_kind == chs_pkg::KIND_INSERT) begin
                    if (r_free != NIL) n_state = chs_pkg::S_FREE_WAIT;
                    else n_state = chs_pkg::S_DONE;
                end else if (r_kind == chs_pkg::KIND_NONE || w_head == NIL) begin
                    n_state = chs_pkg::S_DONE;
                end else begin
                    n_state = chs_pkg::S_NODE_WAIT;
                end
            end
            chs_pkg::S_FREE_WAIT: n_state = chs_pkg::S_DONE;
            chs_pkg::S_NODE_WAIT: begin
                if (r_nkey_q == r_key) begin
                    if (r_kind == chs_pkg::KIND_DELETE) n_state = chs_pkg::S_DEL_FIX;
                    else n_state = chs_pkg::S_DONE;
                end else if (r_nlink_q == NIL || r_steps >= (LW+1)'(NODES - 1)) begin
                    n_state = chs_pkg::S_DONE;
                end
            end
            chs_pkg::S_DEL_FIX: n_state = chs_pkg::S_DONE;
            chs_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = chs_pkg::S_IDLE;
            end
            default: n_state = chs_pkg::S_IDLE;
        endcase
    end

    // Memory control: read the node at cur, write links and heads on updates.
    always_comb begin
        w_hd_we = 1'b0;
        w_hd_wd = r_cur;
        w_nd_re = 1'b0;
        w_nd_ra = r_cur[NW-1:0];
        w_nk_we = 1'b0;
        w_nk_wa = r_cur[NW-1:0];
        w_nl_we = 1'b0;
        w_nl_wa = r_cur[NW-1:0];
        w_nl_wd = w_head;
        unique case (r_state)
            chs_pkg::S_HEAD_WAIT: begin
                if (r_kind == chs_pkg::KIND_INSERT) begin
                    if (r_free != NIL) begin
                        w_nd_re = 1'b1;
                        w_nd_ra = r_free[NW-1:0];
                    end else if (r_fresh != NIL) begin
                        w_nk_we = 1'b1;
                        w_nk_wa = r_fresh[NW-1:0];
                        w_nl_we = 1'b1;
                        w_nl_wa = r_fresh[NW-1:0];
                        w_hd_we = 1'b1;
                        w_hd_wd = r_fresh;
                    end
                end else if (w_head != NIL && r_kind != chs_pkg::KIND_NONE) begin
                    w_nd_re = 1'b1;
                    w_nd_ra = w_head[NW-1:0];
                end
            end
            chs_pkg::S_FREE_WAIT: begin
                w_nk_we = 1'b1;
                w_nk_wa = r_free[NW-1:0];
                w_nl_we = 1'b1;
                w_nl_wa = r_free[NW-1:0];
                w_nl_wd = r_head_q;
                if (!r_head_qv) w_nl_wd = NIL;
                w_hd_we = 1'b1;
                w_hd_wd = r_free;
            end
            chs_pkg::S_NODE_WAIT: begin
                if (r_nkey_q != r_key && r_nlink_q != NIL) begin
                    w_nd_re = 1'b1;
                    w_nd_ra = r_nlink_q[NW-1:0];
                end
            end
            chs_pkg::S_DEL_FIX: begin
                w_nl_we = 1'b1;
                w_nl_wa = r_cur[NW-1:0];
                w_nl_wd = r_free;
                if (r_prev == NIL) begin
                    w_hd_we = 1'b1;
                    w_hd_wd = r_nxt_cur;
                end
            end
            default: ;
        endcase
    end

    // Bucket head memory with per-entry valid bits for the reset state.
    always_ff @(posedge i_clk) begin
        if (w_hd_we) r_heads[r_bkt] <= w_hd_wd;
        r_head_q <= r_heads[r_bkt];
        if (!i_rst_n) begin
            r_hvalid  <= '0;
            r_head_qv <= 1'b0;
        end else begin
            if (w_hd_we) r_hvalid[r_bkt] <= 1'b1;
            r_head_qv <= r_hvalid[r_bkt];
        end
    end

    // Node memories; on a delete the predecessor's link is rewritten at the match,
    // in the cycle before the removed node's own link.
    logic          w_pl_we;
    assign w_pl_we = (r_state == chs_pkg::S_NODE_WAIT) && (r_nkey_q == r_key)
                     && (r_kind == chs_pkg::KIND_DELETE) && (r_prev != NIL);

    always_ff @(posedge i_clk) begin
        if (w_nk_we) r_nkey[w_nk_wa] <= r_key;
        if (w_nl_we) r_nlink[w_nl_wa] <= w_nl_wd;
        else if (w_pl_we) r_nlink[r_prev[NW-1:0]] <= r_nlink_q;
        if (w_nd_re) begin
            r_nkey_q  <= r_nkey[w_nd_ra];
            r_nlink_q <= r_nlink[w_nd_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chs_pkg::S_IDLE;
            r_cfg       <= 7'd64;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (r_state == chs_pkg::S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_key  <= i_in_item.key;
                r_kind <= i_in_item.kind;
            end
            if (r_state == chs_pkg::S_HASH && w_hash_done) begin
                r_bkt        <= BW'(w_rem);
                r_bkt_out    <= w_rem[5:0];
                r_out_status <= chs_pkg::ST_MISSING;
            end
            unique case (r_state)
                chs_pkg::S_HEAD_WAIT: begin
                    r_prev  <= NIL;
                    r_cur   <= w_head;
                    r_steps <= '0;
                    if (r_kind == chs_pkg::KIND_INSERT) begin
                        if (r_free != NIL) begin
                            r_out_status <= chs_pkg::ST_INSERTED;
                        end else if (r_fresh != NIL) begin
                            r_fresh      <= r_fresh + LW'(1);
                            r_out_status <= chs_pkg::ST_INSERTED;
                        end else begin
                            r_out_status <= chs_pkg::ST_FULL;
                        end
                    end
                end
                chs_pkg::S_FREE_WAIT: r_free <= r_nlink_q;
                chs_pkg::S_NODE_WAIT: begin
                    if (r_nkey_q == r_key) begin
                        r_nxt_cur <= r_nlink_q;
                        r_out_status <= (r_kind == chs_pkg::KIND_DELETE) ?
                                        chs_pkg::ST_DELETED : chs_pkg::ST_FOUND;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_nlink_q;
                        r_steps <= r_steps + (LW+1)'(1);
                    end
                end
                chs_pkg::S_DEL_FIX: r_free <= r_cur;
                chs_pkg::S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_bucket <= r_bkt_out;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_item.status = r_out_status_q;
    assign o_out_item.bucket = r_out_bucket;

    always_ff @(posedge i_clk) begin
        if (r_state == chs_pkg::S_DONE && (!r_out_valid || !i_out_stall))
            r_out_status_q <= r_out_status;
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != chs_pkg::S_IDLE) |-> o_in_stall)
        else $error("item accepted while busy");
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL)
        else $error("fresh count beyond pool");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_status_q)))
        else $error("stalled result changed");
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chs_pkg::S_HEAD_RD) |-> ({1'b0, r_bkt_out} < {1'b0, w_div}))
        else $error("bucket out of range");
`endif
endmodule
